### design/dodff_pkg.sv
// Shared constants, codes and types for the dial-on-demand frame filter.
package dodff_pkg;

  localparam int ETH_HDR_BYTES   = 14;
  localparam int IP_HEADER_BYTES = 20;
  localparam int MIN_FRAME_BYTES = 34;

  localparam int POS_W       = 6;
  localparam int SUM_W       = 20;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;

  localparam logic [POS_W-1:0] POS_MAX    = 6'd63;
  localparam logic [POS_W-1:0] MAC_END    = 6'd6;
  localparam logic [POS_W-1:0] ETYPE_HI   = 6'd12;
  localparam logic [POS_W-1:0] ETYPE_LO   = 6'd13;
  localparam logic [POS_W-1:0] IP_FIRST   = POS_W'(ETH_HDR_BYTES);
  localparam logic [POS_W-1:0] IP_END     = POS_W'(ETH_HDR_BYTES + IP_HEADER_BYTES);
  localparam logic [POS_W-1:0] SHORT_POS  = POS_W'(MIN_FRAME_BYTES);
  localparam logic [POS_W-1:0] DADDR_OFFS = 6'd16;
  localparam logic [3:0]       CHECK_WORD = 4'd5;

  localparam logic [15:0] IPV4_TYPE = 16'h0800;

  // verdict reason codes
  localparam logic [2:0] RSN_OK       = 3'd0;
  localparam logic [2:0] RSN_SHORT    = 3'd1;
  localparam logic [2:0] RSN_WRONGMAC = 3'd2;
  localparam logic [2:0] RSN_TO_LAN   = 3'd3;
  localparam logic [2:0] RSN_NOT_IPV4 = 3'd4;
  localparam logic [2:0] RSN_BAD_CSUM = 3'd5;
  localparam logic [2:0] RSN_OFFNET   = 3'd6;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STATION_MAC = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAN_ADDR    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REF_ADDR    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUBNET_MASK = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFNET_TRIG = 3'd4;

  // frame state carried from parser to verdict logic
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             mac_ok;
    logic [15:0]      ethertype;
    logic [SUM_W-1:0] sum;
    logic [15:0]      check;
    logic [31:0]      daddr;
  } frame_state_t;

  // frame state at reset and between frames
  localparam frame_state_t FRAME_IDLE = '{pos: '0, mac_ok: 1'b1, ethertype: '0,
                                          sum: '0, check: '0, daddr: '0};

  typedef struct packed {
    logic [47:0] station_mac;
    logic [31:0] lan_addr;
    logic [31:0] ref_addr;
    logic [31:0] mask;
    logic        offnet_trig;
  } cfg_regs_t;

endpackage

### design/dodff_ifs.sv
// Valid/ready channel interfaces for frame bytes and verdict items.
interface dodff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface dodff_out_if;
  logic       valid;
  logic       ready;
  logic       trigger;
  logic [2:0] reason;

  modport source (output valid, output trigger, output reason, input ready);
  modport sink (input valid, input trigger, input reason, output ready);
endinterface

### design/dial_on_demand_frame_filter.sv
// Top level of the dial-on-demand frame filter.
// Takes an Ethernet frame one byte per item on in_chan, last_byte set on the final byte,
// and gives one verdict item on out_chan per frame: trigger (start a dial-up) and a
// reason code (0 accepted, 1 short, 2 wrong MAC, 3 to LAN, 4 not IPv4, 5 bad checksum,
// 6 off-subnet). Bytes stream at one per cycle; a stalled verdict only holds back a
// later frame's last byte. An input register holds the byte, the parser updates running
// frame state from it, and on the last byte the verdict logic loads the result register.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while no
// frame is in flight; the block does not check. Index 0 station MAC (first wire byte in
// bits 47:40), 1 LAN address, 2 reference address, 3 subnet mask, 4 off-subnet trigger
// enable. Addresses are in network order; other indexes are ignored.
module dial_on_demand_frame_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  dodff_in_if.sink                          in_chan,
  dodff_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [dodff_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dodff_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dodff_pkg::*;

  cfg_regs_t    cfg_r;
  frame_state_t fstate;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       in_take;

  // result register
  logic       out_valid_r;
  logic       trig_r;
  logic [2:0] reason_r;
  logic       v_trig;
  logic [2:0] v_reason;

  // a mid-frame byte never needs the result register; a last byte waits for it
  assign s1_go   = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_take = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATION_MAC: cfg_r.station_mac <= cfg_data;
        CFG_LAN_ADDR:    cfg_r.lan_addr    <= cfg_data[31:0];
        CFG_REF_ADDR:    cfg_r.ref_addr    <= cfg_data[31:0];
        CFG_SUBNET_MASK: cfg_r.mask        <= cfg_data[31:0];
        CFG_OFFNET_TRIG: cfg_r.offnet_trig <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.frame_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  dodff_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (s1_go),
    .byte_in     (s1_byte_r),
    .last_in     (s1_last_r),
    .station_mac (cfg_r.station_mac),
    .state       (fstate)
  );

  dodff_verdict u_verdict (
    .state   (fstate),
    .cfg     (cfg_r),
    .trigger (v_trig),
    .reason  (v_reason)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      trig_r   <= v_trig;
      reason_r <= v_reason;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.trigger = trig_r;
  assign out_chan.reason  = reason_r;
endmodule

### design/dodff_parse.sv
// Per-byte frame parser: MAC compare, EtherType, header checksum sum, IPv4 destination.
module dodff_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [7:0]                 byte_in,
  input  logic                       last_in,
  input  logic [47:0]                station_mac,
  output dodff_pkg::frame_state_t    state
);
  import dodff_pkg::*;

  frame_state_t st_r, st_upd, st_nxt;
  logic [47:0]      mac_sh;
  logic [POS_W-1:0] ip_idx;
  logic [15:0]      word;
  logic [7:0]       hold_r, hold_nxt;

  assign mac_sh = station_mac << {st_r.pos[2:0], 3'b000};
  assign ip_idx = st_r.pos - IP_FIRST;
  assign word   = {hold_r, byte_in};

  always_comb begin
    st_upd   = st_r;
    hold_nxt = hold_r;
    if (st_r.pos < MAC_END) begin
      if (mac_sh[47:40] != byte_in) st_upd.mac_ok = 1'b0;
    end else if (st_r.pos == ETYPE_HI || st_r.pos == ETYPE_LO) begin
      st_upd.ethertype = {st_r.ethertype[7:0], byte_in};
    end else if (st_r.pos >= IP_FIRST && st_r.pos < IP_END) begin
      if (!ip_idx[0]) begin
        hold_nxt = byte_in;
      end else if (ip_idx[4:1] == CHECK_WORD) begin
        st_upd.check = word;
      end else begin
        st_upd.sum = st_r.sum + {4'b0, word};
      end
      if (ip_idx >= DADDR_OFFS) st_upd.daddr = {st_r.daddr[23:0], byte_in};
    end
    if (st_r.pos != POS_MAX) st_upd.pos = st_r.pos + 1'b1;
    // after the last byte all frame state returns to FRAME_IDLE for the next frame
    st_nxt = st_upd;
    if (last_in) begin
      st_nxt   = FRAME_IDLE;
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FRAME_IDLE;
      hold_r <= '0;
    end else if (take) begin
      st_r   <= st_nxt;
      hold_r <= hold_nxt;
    end
  end

  // the verdict sees the state with the current byte already applied
  assign state = st_upd;
endmodule

### design/dodff_verdict.sv
// Verdict logic: ordered drop checks, checksum fold and subnet rule.
module dodff_verdict (
  input  dodff_pkg::frame_state_t state,
  input  dodff_pkg::cfg_regs_t    cfg,
  output logic                    trigger,
  output logic [2:0]              reason
);
  import dodff_pkg::*;

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;

  // end-around carry twice, then invert
  assign fold1 = {1'b0, state.sum[15:0]} + {13'b0, state.sum[19:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};
  assign csum  = ~fold2;

  // pos already counts the closing byte (saturated at 63)
  always_comb begin
    trigger = 1'b0;
    priority if (state.pos < SHORT_POS) begin
      reason = RSN_SHORT;
    end else if (!state.mac_ok) begin
      reason = RSN_WRONGMAC;
    end else if (state.daddr == cfg.lan_addr) begin
      reason = RSN_TO_LAN;
    end else if (state.ethertype != IPV4_TYPE) begin
      reason = RSN_NOT_IPV4;
    end else if (csum != state.check) begin
      reason = RSN_BAD_CSUM;
    end else if ((cfg.ref_addr & cfg.mask) != (state.daddr & cfg.mask)) begin
      trigger = cfg.offnet_trig;
      reason  = cfg.offnet_trig ? RSN_OK : RSN_OFFNET;
    end else begin
      trigger = 1'b1;
      reason  = RSN_OK;
    end
  end
endmodule

### design/dodff_checker.sv
// Port-level checker for the frame filter and its bind.
module dodff_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_trigger,
  input logic [2:0] out_reason
);
  import dodff_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_trigger) && $stable(out_reason))
    else $error("verdict changed while stalled");

  a_trig_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger |-> out_reason == RSN_OK)
    else $error("trigger with a drop reason");

  a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_trigger |-> out_reason != RSN_OK && out_reason <= RSN_OFFNET)
    else $error("drop without a valid reason");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict shown right after reset");

endmodule

bind dial_on_demand_frame_filter dodff_checker u_dodff_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_trigger (out_chan.trigger),
  .out_reason  (out_chan.reason)
);
